// ----- rtl/aabb_build_and_ray_hit_top_macros.svh -----
// assertion macros for the box and ray block
`ifndef AABB_BUILD_AND_RAY_HIT_TOP_MACROS_SVH
`define AABB_BUILD_AND_RAY_HIT_TOP_MACROS_SVH
// antecedent implies consequent in the same cycle
`define ARH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the next cycle
`define ARH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/arh_pkg.sv -----
// shared types and constants for the box and ray block
package arh_pkg;
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int CAP_BITS  = 40;
	localparam int NUM_W     = COORD_W + FRAC_BITS;
	localparam int QUO_W     = COORD_W - 1;
	localparam int DS_W      = COORD_W + QUO_W - 1;
	localparam int PROD_W    = COORD_W + QUO_W;
	localparam int M_W       = CAP_BITS + 1;
	localparam int H_W       = M_W + 2;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic       accept;
		logic       div_init;
		logic       div_step;
		logic       mul;
		logic       cmp;
		logic [1:0] axis;
		logic [1:0] kax;
	} arh_cmd_t;

	typedef struct packed {
		logic empty;
		logic axis_ok;
		logic t_zero;
		logic all_in;
	} arh_sts_t;

	function automatic logic [COORD_W-1:0] mag_f(input coord_t v);
		mag_f = v[COORD_W-1] ? (~v + COORD_W'(1)) : v;
	endfunction
endpackage

// ----- rtl/arh_dp.sv -----
// datapath: box corners, request registers, shared divider, multiplier and hit test
module arh_dp import arh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] op,
	input  coord_t     px,
	input  coord_t     py,
	input  coord_t     pz,
	input  coord_t     dx,
	input  coord_t     dy,
	input  coord_t     dz,
	input  arh_cmd_t   cmd,
	output arh_sts_t   sts
);
	localparam coord_t CMAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [M_W-1:0] CAP = {1'b1, {CAP_BITS{1'b0}}};

	coord_t bmin_q [3];
	coord_t bmax_q [3];
	coord_t p_q [3];
	coord_t d_q [3];
	logic [NUM_W-1:0]  rem_q;
	logic [DS_W-1:0]   ds_q;
	logic [QUO_W-1:0]  quo_q;
	logic              sat_q;
	logic              ok_q;
	logic              inside_q;
	logic [PROD_W-1:0] prod_q;

	coord_t            pa, da, face, pk, dk, in_p [3];
	logic signed [COORD_W:0] n;
	logic [COORD_W-1:0] nmag, dmag, dkmag;
	logic              ok, sat, in_box;
	logic [QUO_W-1:0]  t;
	logic [M_W-1:0]    m;
	logic signed [H_W-1:0] h, hmin, hmax;

	always_comb begin
		in_p[0] = px;
		in_p[1] = py;
		in_p[2] = pz;
		pa   = p_q[cmd.axis];
		da   = d_q[cmd.axis];
		face = da[COORD_W-1] ? bmax_q[cmd.axis] : bmin_q[cmd.axis];
		n    = (COORD_W+1)'(face) - (COORD_W+1)'(pa);
		nmag = n[COORD_W] ? COORD_W'(-n) : n[COORD_W-1:0];
		dmag = mag_f(da);
		ok   = (da != '0) && (n != '0) && (n[COORD_W] == da[COORD_W-1]);
		sat  = {(FRAC_BITS-1)'(0), nmag} >= {dmag, (FRAC_BITS-1)'(0)};
		t    = sat_q ? {QUO_W{1'b1}} : quo_q;
		pk   = p_q[cmd.kax];
		dk   = d_q[cmd.kax];
		dkmag = mag_f(dk);
		if (prod_q[PROD_W-1:FRAC_BITS] > (PROD_W-FRAC_BITS)'(CAP))
			m = CAP;
		else
			m = prod_q[FRAC_BITS+M_W-1:FRAC_BITS];
		h    = dk[COORD_W-1] ? (H_W'(pk) - H_W'(m)) : (H_W'(pk) + H_W'(m));
		hmin = H_W'(bmin_q[cmd.kax]);
		hmax = H_W'(bmax_q[cmd.kax]);
		in_box = (h > hmin) && (h < hmax);
		sts.empty = (bmin_q[0] > bmax_q[0]) || (bmin_q[1] > bmax_q[1])
			|| (bmin_q[2] > bmax_q[2]);
		sts.axis_ok = ok_q;
		sts.t_zero  = !sat_q && (quo_q == '0);
		sts.all_in  = inside_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				bmin_q[a] <= CMAX;
				bmax_q[a] <= CMIN;
			end
		end else if (cmd.accept) begin
			unique case (op)
				OP_CLEAR: begin
					for (int a = 0; a < 3; a++) begin
						bmin_q[a] <= CMAX;
						bmax_q[a] <= CMIN;
					end
				end
				OP_ADD: begin
					for (int a = 0; a < 3; a++) begin
						if (in_p[a] > bmax_q[a]) bmax_q[a] <= in_p[a];
						if (in_p[a] < bmin_q[a]) bmin_q[a] <= in_p[a];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			p_q[0] <= px;
			p_q[1] <= py;
			p_q[2] <= pz;
			d_q[0] <= dx;
			d_q[1] <= dy;
			d_q[2] <= dz;
		end
		if (cmd.div_init) begin
			ok_q     <= ok;
			sat_q    <= sat;
			inside_q <= 1'b1;
			rem_q    <= {nmag, FRAC_BITS'(0)};
			ds_q     <= {dmag, (QUO_W-1)'(0)};
			quo_q    <= '0;
		end
		if (cmd.div_step) begin
			if (DS_W'(rem_q) >= ds_q) begin
				rem_q <= rem_q - ds_q[NUM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			ds_q <= ds_q >> 1;
		end
		if (cmd.mul)
			prod_q <= PROD_W'(dkmag) * PROD_W'(t);
		if (cmd.cmp && !in_box)
			inside_q <= 1'b0;
	end
endmodule

// ----- rtl/arh_ctrl.sv -----
// controller: request handshake, query sequencing and result register
module arh_ctrl import arh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       hit,
	output arh_cmd_t   cmd,
	input  arh_sts_t   sts
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_EMPTY, ST_AXIS, ST_CHECK, ST_DIV, ST_TCHK,
		ST_MUL1, ST_CMP1, ST_MUL2, ST_CMP2, ST_DECIDE, ST_FIN
	} state_t;

	state_t     state_q;
	logic [1:0] axis_q;
	logic [4:0] cnt_q;
	logic       res_q;
	logic       out_valid_q;
	logic       hit_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign hit       = hit_q;

	always_comb begin
		cmd          = '0;
		cmd.axis     = axis_q;
		cmd.kax      = (axis_q == 2'd0) ? 2'd1 : 2'd0;
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.div_init = (state_q == ST_AXIS);
		cmd.div_step = (state_q == ST_DIV);
		cmd.mul      = (state_q == ST_MUL1) || (state_q == ST_MUL2);
		cmd.cmp      = (state_q == ST_CMP1) || (state_q == ST_CMP2);
		if (state_q == ST_MUL2 || state_q == ST_CMP2)
			cmd.kax = (axis_q == 2'd2) ? 2'd1 : 2'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			cnt_q       <= '0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FIN)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && op == OP_QUERY)
						state_q <= ST_EMPTY;
				end
				ST_EMPTY: begin
					axis_q <= '0;
					res_q  <= 1'b0;
					state_q <= sts.empty ? ST_FIN : ST_AXIS;
				end
				ST_AXIS: state_q <= ST_CHECK;
				ST_CHECK: begin
					cnt_q <= 5'(QUO_W - 1);
					if (sts.axis_ok)
						state_q <= ST_DIV;
					else if (axis_q == 2'd2)
						state_q <= ST_FIN;
					else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_AXIS;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0)
						state_q <= ST_TCHK;
				end
				ST_TCHK: begin
					if (!sts.t_zero)
						state_q <= ST_MUL1;
					else if (axis_q == 2'd2)
						state_q <= ST_FIN;
					else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_AXIS;
					end
				end
				ST_MUL1: state_q <= ST_CMP1;
				ST_CMP1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_CMP2;
				ST_CMP2: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (sts.all_in) begin
						res_q   <= 1'b1;
						state_q <= ST_FIN;
					end else if (axis_q == 2'd2)
						state_q <= ST_FIN;
					else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_AXIS;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						hit_q       <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/aabb_build_and_ray_hit_top.sv -----
// top level: box build and ray hit test
// clear and add requests do not stall; the next request is taken the cycle after
// a query tries the axes in turn until one hits; per usable axis a divider run,
// then, unless t is zero, two multiply/compare passes on one shared 32x31 multiplier
// the result sits in an output register, so a new request is taken while it waits
// asynchronous reset empties the box and clears the handshake state
module aabb_build_and_ray_hit_top import arh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  coord_t     px,
	input  coord_t     py,
	input  coord_t     pz,
	input  coord_t     dx,
	input  coord_t     dy,
	input  coord_t     dz,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       hit
);
	`include "aabb_build_and_ray_hit_top_macros.svh"

	arh_cmd_t cmd;
	arh_sts_t sts;

	arh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .cmd(cmd), .sts(sts)
	);

	arh_dp u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .px(px), .py(py), .pz(pz),
		.dx(dx), .dy(dy), .dz(dz), .cmd(cmd), .sts(sts)
	);

	`ARH_ASSERT_NEXT(a_query_holds, in_valid && !in_stall && op == OP_QUERY, in_stall, "query not held")
	`ARH_ASSERT_NEXT(a_no_spurious, in_valid && !in_stall && op != OP_QUERY && !out_valid, !out_valid, "result without query")
	`ARH_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.accept, cmd.div_init, cmd.div_step, cmd.mul, cmd.cmp}), "commands overlap")
endmodule
